// ----- hdl/rlm_pkg.sv -----
// Package for the resource lock manager: widths, status and register codes,
// item structs and the wait-list sequencer states.
// No dependencies; imported by every module of the block.
package rlm_pkg;

	// Default sizes for the top-level parameters
	localparam int RES_SLOTS_DEF = 8;
	localparam int PROC_MAX_DEF  = 16;

	// Field widths
	localparam int PROC_W     = 4;
	localparam int KIND_W     = 4;
	localparam int SLOT_W     = 3;
	localparam int STAT_W     = 3;
	localparam int CNT_CFG_W  = 4;
	localparam int PROC_IDS   = 2 ** PROC_W;
	localparam int KIND_SLOTS = 8;

	// Configuration port
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic REG_KINDS = 1'b0;
	localparam logic REG_COUNT = 1'b1;
	localparam logic [APB_DW-1:0] KINDS_RST = '0;
	localparam logic [CNT_CFG_W-1:0] COUNT_RST = CNT_CFG_W'(8);

	// Request types
	localparam logic REQ_ACQUIRE = 1'b0;
	localparam logic REQ_RELEASE = 1'b1;

	// Result status codes
	localparam logic [STAT_W-1:0] ST_GRANTED   = 3'd0;
	localparam logic [STAT_W-1:0] ST_WAIT      = 3'd1;
	localparam logic [STAT_W-1:0] ST_RELEASED  = 3'd2;
	localparam logic [STAT_W-1:0] ST_REL_ERROR = 3'd3;
	localparam logic [STAT_W-1:0] ST_ALREADY   = 3'd4;

	// Input and result items
	typedef struct packed {
		logic              req_type;
		logic [PROC_W-1:0] proc_id;
		logic [KIND_W-1:0] res_kind;
	} cmd_item_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [SLOT_W-1:0] slot_index;
		logic              woken_valid;
		logic [PROC_W-1:0] woken_proc;
	} rsp_item_t;

	// Slot table lookup results
	typedef struct packed {
		logic              grant_hit;
		logic [SLOT_W-1:0] grant_idx;
		logic              rel_hit;
		logic [SLOT_W-1:0] rel_idx;
	} slot_res_t;

	// Wait-list memory entry
	typedef struct packed {
		logic [PROC_W-1:0] proc;
		logic [KIND_W-1:0] kind;
	} wl_entry_t;

	// Wait-list control and status
	typedef struct packed {
		logic              push;
		logic              start;
		logic [PROC_W-1:0] proc;
		logic [KIND_W-1:0] kind;
	} wl_cmd_t;

	typedef struct packed {
		logic              busy;
		logic              empty;
		logic              full;
		logic              done;
		logic              woken_valid;
		logic [PROC_W-1:0] woken_proc;
	} wl_stat_t;

	typedef enum logic [1:0] {
		WL_IDLE,
		WL_SCAN,
		WL_SHIFT
	} wl_state_t;

endpackage

// ----- hdl/rlm_slot_table.sv -----
// Slot table: busy bits and owners of the resource slots, with the
// lowest-free-slot grant search and the owner match for releases.
// Depends on rlm_pkg.
module rlm_slot_table #(
	parameter int RES_SLOTS = rlm_pkg::RES_SLOTS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic [rlm_pkg::APB_DW-1:0]             slot_kinds,
	input  logic [rlm_pkg::CNT_CFG_W-1:0]          slot_count,
	input  logic [rlm_pkg::PROC_W-1:0]             proc,
	input  logic [rlm_pkg::KIND_W-1:0]             kind,
	input  logic                                   grant_en,
	input  logic                                   release_en,
	output rlm_pkg::slot_res_t                     res
);
	import rlm_pkg::*;

	// Only the slots that have a kind nibble can ever be live
	localparam int LIVE = (RES_SLOTS < KIND_SLOTS) ? RES_SLOTS : KIND_SLOTS;

	logic [LIVE-1:0]   busy_q;
	logic [PROC_W-1:0] owner_q [LIVE];

	// Priority search; walking down leaves the lowest slot as the winner
	always_comb begin
		res = '0;
		for (int i = LIVE - 1; i >= 0; i--) begin
			if (slot_count > CNT_CFG_W'(i) && slot_kinds[i*KIND_W +: KIND_W] == kind) begin
				if (!busy_q[i]) begin
					res.grant_hit = 1'b1;
					res.grant_idx = SLOT_W'(i);
				end
				if (busy_q[i] && owner_q[i] == proc) begin
					res.rel_hit = 1'b1;
					res.rel_idx = SLOT_W'(i);
				end
			end
		end
	end

	// Busy bits: cleared at reset so every slot starts free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
		end else begin
			for (int i = 0; i < LIVE; i++) begin
				if (grant_en && res.grant_idx == SLOT_W'(i)) begin
					busy_q[i] <= 1'b1;
				end
				if (release_en && res.rel_idx == SLOT_W'(i)) begin
					busy_q[i] <= 1'b0;
				end
			end
		end
	end

	// Owner ids, only meaningful while busy
	always_ff @(posedge clk) begin
		for (int i = 0; i < LIVE; i++) begin
			if (grant_en && res.grant_idx == SLOT_W'(i)) begin
				owner_q[i] <= proc;
			end
		end
	end

endmodule

// ----- hdl/rlm_wait_list.sv -----
// Wait list: FIFO of waiting processes held in a synchronous memory, with a
// sequencer that scans for the oldest waiter of a kind and compacts the list.
// Depends on rlm_pkg.
module rlm_wait_list #(
	parameter int PROC_MAX = rlm_pkg::PROC_MAX_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rlm_pkg::wl_cmd_t           cmd,
	input  logic [rlm_pkg::PROC_W-1:0] query_proc,
	output logic                       waiting,
	output rlm_pkg::wl_stat_t          stat
);
	import rlm_pkg::*;

	localparam int IDX_W = $clog2(PROC_MAX);
	localparam int CNT_W = $clog2(PROC_MAX + 1);

	wl_entry_t mem [PROC_MAX];
	wl_entry_t rdata_q;

	wl_state_t         state_q, state_d;
	logic [IDX_W-1:0]  ptr_q, ptr_d, ptr_inc;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [KIND_W-1:0] kind_q;
	logic [PROC_W-1:0] wproc_q, wproc_d;
	logic [PROC_IDS-1:0] flags_q;

	logic             more;
	logic             rd_en, wr_en;
	logic [IDX_W-1:0] rd_addr, wr_addr;
	wl_entry_t        wr_data;
	logic             set_flag, clr_flag;

	assign ptr_inc = ptr_q + IDX_W'(1);
	assign more    = (CNT_W'(ptr_q) + CNT_W'(1)) < count_q;

	// Sequencer: push or start a scan when idle, then scan entries and shift the tail down
	always_comb begin
		state_d  = state_q;
		ptr_d    = ptr_q;
		count_d  = count_q;
		wproc_d  = wproc_q;
		rd_en    = 1'b0;
		rd_addr  = ptr_inc;
		wr_en    = 1'b0;
		wr_addr  = count_q[IDX_W-1:0];
		wr_data  = '{proc: cmd.proc, kind: cmd.kind};
		set_flag = 1'b0;
		clr_flag = 1'b0;
		stat.busy        = (state_q != WL_IDLE);
		stat.empty       = (count_q == '0);
		stat.full        = (count_q == CNT_W'(PROC_MAX));
		stat.done        = 1'b0;
		stat.woken_valid = 1'b0;
		stat.woken_proc  = '0;
		case (state_q)
			WL_IDLE: begin
				if (cmd.push) begin
					wr_en    = 1'b1;
					count_d  = count_q + CNT_W'(1);
					set_flag = 1'b1;
				end
				if (cmd.start) begin
					rd_en   = 1'b1;
					rd_addr = '0;
					ptr_d   = '0;
					state_d = WL_SCAN;
				end
			end
			WL_SCAN: begin
				if (rdata_q.kind == kind_q) begin
					clr_flag = 1'b1;
					wproc_d  = rdata_q.proc;
					if (more) begin
						rd_en   = 1'b1;
						ptr_d   = ptr_inc;
						state_d = WL_SHIFT;
					end else begin
						count_d          = count_q - CNT_W'(1);
						stat.done        = 1'b1;
						stat.woken_valid = 1'b1;
						stat.woken_proc  = rdata_q.proc;
						state_d          = WL_IDLE;
					end
				end else if (more) begin
					rd_en = 1'b1;
					ptr_d = ptr_inc;
				end else begin
					stat.done = 1'b1;
					state_d   = WL_IDLE;
				end
			end
			WL_SHIFT: begin
				// entry at ptr moves down one place
				wr_en   = 1'b1;
				wr_addr = ptr_q - IDX_W'(1);
				wr_data = rdata_q;
				if (more) begin
					rd_en = 1'b1;
					ptr_d = ptr_inc;
				end else begin
					count_d          = count_q - CNT_W'(1);
					stat.done        = 1'b1;
					stat.woken_valid = 1'b1;
					stat.woken_proc  = wproc_q;
					state_d          = WL_IDLE;
				end
			end
			default: begin
				state_d = WL_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= WL_IDLE;
			count_q <= '0;
			flags_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (set_flag) begin
				flags_q[cmd.proc] <= 1'b1;
			end
			if (clr_flag) begin
				flags_q[rdata_q.proc] <= 1'b0;
			end
		end
	end

	// Scan pointer and captured search values
	always_ff @(posedge clk) begin
		ptr_q   <= ptr_d;
		wproc_q <= wproc_d;
		if (cmd.start && state_q == WL_IDLE) begin
			kind_q <= cmd.kind;
		end
	end

	// Wait-list memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	assign waiting = flags_q[query_proc];

endmodule

// ----- hdl/resource_lock_manager.sv -----
// Resource lock manager: a hardware mutex over typed resource slots with a
// FIFO wait list of blocked processes.
//
// Channels: cmd carries one access (request or release, process, kind) and
// is taken on a clock edge with cmd_valid high and cmd_stall low. rsp gives
// one result item per access, taken when rsp_valid is high and rsp_stall low.
// Slot kinds and the slot count are set over the APB port at byte 0 and 4;
// the user sets them only while no access is in flight (not enforced).
// A request, a failed release, or a release with an empty wait list has its
// result written into the output register, or the holding stage while rsp is
// stalled. A good release with waiters walks the wait-list memory one entry a
// cycle, the removal of the woken entry included, before its result is made.
// Requests are taken at one access per cycle while cmd_stall stays low; a good
// release with waiters is bound by the single read port of the wait-list memory.
// The output register and a one-entry result holding stage let the next
// access be taken while a result waits; cmd_stall rises only when that stage
// is full or a wait-list walk is running.
// Reset frees every slot, empties the wait list, clears slot_kinds and sets
// slot_count to 8. A stalled receiver holds rsp steady until it is taken.
// Depends on rlm_pkg, rlm_slot_table and rlm_wait_list.
module resource_lock_manager #(
	parameter int RES_SLOTS = rlm_pkg::RES_SLOTS_DEF,
	parameter int PROC_MAX  = rlm_pkg::PROC_MAX_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration port
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rlm_pkg::APB_AW-1:0] paddr,
	input  logic [rlm_pkg::APB_DW-1:0] pwdata,
	output logic [rlm_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	// access channel
	input  logic                       cmd_valid,
	output logic                       cmd_stall,
	input  rlm_pkg::cmd_item_t         cmd,
	// result channel
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output rlm_pkg::rsp_item_t         rsp
);
	import rlm_pkg::*;

	logic [APB_DW-1:0]    slot_kinds_q;
	logic [CNT_CFG_W-1:0] slot_count_q;

	slot_res_t slot_res;
	logic      grant_en, release_en;
	wl_cmd_t   wl_cmd;
	wl_stat_t  wl_stat;
	logic      waiting;

	logic              accept;
	logic              new_valid;
	rsp_item_t         new_res;
	logic [SLOT_W-1:0] rel_idx_q;
	rsp_item_t         res_q, out_q;
	logic              pend_q, out_valid_q;
	logic              out_free;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_kinds_q <= KINDS_RST;
			slot_count_q <= COUNT_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_KINDS: slot_kinds_q <= pwdata;
				REG_COUNT: slot_count_q <= pwdata[CNT_CFG_W-1:0];
				default:   slot_kinds_q <= slot_kinds_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_KINDS: prdata = slot_kinds_q;
			REG_COUNT: prdata = APB_DW'(slot_count_q);
			default:   prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	rlm_slot_table #(
		.RES_SLOTS (RES_SLOTS)
	) u_slots (
		.clk        (clk),
		.arst_n     (arst_n),
		.slot_kinds (slot_kinds_q),
		.slot_count (slot_count_q),
		.proc       (cmd.proc_id),
		.kind       (cmd.res_kind),
		.grant_en   (grant_en),
		.release_en (release_en),
		.res        (slot_res)
	);

	rlm_wait_list #(
		.PROC_MAX (PROC_MAX)
	) u_waiters (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (wl_cmd),
		.query_proc (cmd.proc_id),
		.waiting    (waiting),
		.stat       (wl_stat)
	);

	assign cmd_stall = wl_stat.busy || pend_q;
	assign accept    = cmd_valid && !cmd_stall;

	// Decide the access and build its result
	always_comb begin
		new_valid   = 1'b0;
		new_res     = '0;
		grant_en    = 1'b0;
		release_en  = 1'b0;
		wl_cmd      = '0;
		wl_cmd.proc = cmd.proc_id;
		wl_cmd.kind = cmd.res_kind;
		if (accept) begin
			if (cmd.req_type == REQ_ACQUIRE) begin
				new_valid = 1'b1;
				if (waiting) begin
					new_res.status = ST_ALREADY;
				end else if (slot_res.grant_hit) begin
					grant_en           = 1'b1;
					new_res.status     = ST_GRANTED;
					new_res.slot_index = slot_res.grant_idx;
				end else begin
					new_res.status = ST_WAIT;
					wl_cmd.push    = !wl_stat.full;
				end
			end else begin
				if (slot_res.rel_hit) begin
					release_en = 1'b1;
					if (wl_stat.empty) begin
						new_valid          = 1'b1;
						new_res.status     = ST_RELEASED;
						new_res.slot_index = slot_res.rel_idx;
					end else begin
						wl_cmd.start = 1'b1;
					end
				end else begin
					new_valid      = 1'b1;
					new_res.status = ST_REL_ERROR;
				end
			end
		end
		// release finishing after the wait-list walk
		if (wl_stat.done) begin
			new_valid           = 1'b1;
			new_res.status      = ST_RELEASED;
			new_res.slot_index  = rel_idx_q;
			new_res.woken_valid = wl_stat.woken_valid;
			new_res.woken_proc  = wl_stat.woken_proc;
		end
	end

	always_ff @(posedge clk) begin
		if (wl_cmd.start) begin
			rel_idx_q <= slot_res.rel_idx;
		end
	end

	// Output register with a one-entry holding stage behind it
	assign out_free = !out_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= pend_q || new_valid;
			pend_q      <= 1'b0;
		end else if (new_valid) begin
			pend_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= pend_q ? res_q : new_res;
		end else if (new_valid) begin
			res_q <= new_res;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

// ----- tb/tb_resource_lock_manager.sv -----
// Self-checking testbench for resource_lock_manager: directed accesses, then random
// phases under several slot maps and counts, with every result checked against its planned value or the model.
// Depends on rlm_pkg and the resource_lock_manager RTL.
module tb_resource_lock_manager;
	timeunit 1ns;
	timeprecision 1ps;
	import rlm_pkg::*;

	localparam int NSLOT = RES_SLOTS_DEF;
	localparam int WL_DEPTH = PROC_MAX_DEF;
	localparam int LIMIT = 200000;
	localparam int LONG_HOLD = 80;
	localparam int TAIL = WL_DEPTH + 10;
	localparam int PHASES = 8;

	typedef enum logic [1:0] {ROW_ACCESS, ROW_KINDS, ROW_COUNT} row_e;

	typedef struct {
		row_e        what;
		cmd_item_t   c;
		logic [31:0] val;
		bit          known;
		rsp_item_t   want;
	} plan_row_t;

	typedef struct packed {
		logic      known;
		rsp_item_t want;
	} typed_rsp_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata, prdata;
	logic pready;
	logic cmd_valid, cmd_stall;
	cmd_item_t cmd;
	logic rsp_valid, rsp_stall;
	rsp_item_t rsp;

	resource_lock_manager uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	// Lock table model: slot map, slot owners and the FIFO of waiters
	logic [31:0]          kinds_m;
	logic [CNT_CFG_W-1:0] count_m;
	logic                 own_busy [NSLOT];
	logic [PROC_W-1:0]    own_proc [NSLOT];
	wl_entry_t            waiters[$];
	wl_entry_t            woken_pool[$];

	rsp_item_t  due_q[$];
	typed_rsp_t typed_q[$];

	int  errs = 0;
	int  cycles = 0;
	int  reg_writes = 0;
	int  tally [5] = '{0, 0, 0, 0, 0};
	int  wakes = 0;
	int  gap_pct = 0;
	bit  hold_rsp = 1'b0;
	int  phase_len [PHASES] = '{90, 50, 90, 90, 90, 90, 90, 110};

	// Clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
				cycles, due_q.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic logic [KIND_W-1:0] kind_of_slot(int s);
		return kinds_m[4*s +: 4];
	endfunction

	function automatic int live_slots();
		return (int'(count_m) > NSLOT) ? NSLOT : int'(count_m);
	endfunction

	// Apply one access to the lock table and return its result
	function automatic rsp_item_t lock_access(cmd_item_t c);
		rsp_item_t r;
		bit hit;
		bit waiting;
		r = '0;
		hit = 1'b0;
		waiting = 1'b0;
		if (c.req_type == REQ_ACQUIRE) begin
			foreach (waiters[i])
				if (waiters[i].proc == c.proc_id) waiting = 1'b1;
			if (waiting) begin
				r.status = ST_ALREADY;
			end else begin
				r.status = ST_WAIT;
				for (int s = 0; s < live_slots() && !hit; s++) begin
					if (!own_busy[s] && kind_of_slot(s) == c.res_kind) begin
						own_busy[s] = 1'b1;
						own_proc[s] = c.proc_id;
						r.status = ST_GRANTED;
						r.slot_index = SLOT_W'(s);
						hit = 1'b1;
					end
				end
				// full list: the requester is told to wait but is not queued
				if (!hit && waiters.size() < WL_DEPTH)
					waiters.push_back('{proc: c.proc_id, kind: c.res_kind});
			end
		end else begin
			r.status = ST_REL_ERROR;
			for (int s = 0; s < live_slots() && !hit; s++) begin
				if (own_busy[s] && own_proc[s] == c.proc_id &&
					kind_of_slot(s) == c.res_kind) begin
					own_busy[s] = 1'b0;
					own_proc[s] = '0;
					r.status = ST_RELEASED;
					r.slot_index = SLOT_W'(s);
					hit = 1'b1;
				end
			end
			// wake the oldest waiter for this kind
			if (hit) begin
				for (int i = 0; i < waiters.size(); i++) begin
					if (waiters[i].kind == c.res_kind) begin
						r.woken_valid = 1'b1;
						r.woken_proc = waiters[i].proc;
						woken_pool.push_back(waiters[i]);
						waiters.delete(i);
						break;
					end
				end
			end
		end
		return r;
	endfunction

	// Random access, mostly well formed: owner releases, re-requests by woken
	// processes, requests for kinds that exist; a tail of pure noise
	function automatic cmd_item_t next_access();
		cmd_item_t c;
		wl_entry_t e;
		int pick;
		int s;
		int held[$];
		pick = $urandom_range(0, 99);
		for (int i = 0; i < live_slots(); i++)
			if (own_busy[i]) held.push_back(i);
		c.req_type = REQ_ACQUIRE;
		c.proc_id = PROC_W'($urandom_range(0, 15));
		c.res_kind = ($urandom_range(0, 4) != 0) ? kind_of_slot($urandom_range(0, 7)) :
			KIND_W'($urandom_range(0, 15));
		if (pick < 10 && woken_pool.size() != 0) begin
			e = woken_pool.pop_front();
			c.proc_id = e.proc;
			c.res_kind = e.kind;
		end else if (pick < 45 && held.size() != 0) begin
			s = held[$urandom_range(0, held.size() - 1)];
			c.req_type = REQ_RELEASE;
			c.proc_id = own_proc[s];
			c.res_kind = kind_of_slot(s);
		end else if (pick >= 88) begin
			c.req_type = 1'($urandom_range(0, 1));
			c.res_kind = KIND_W'($urandom_range(0, 15));
		end
		return c;
	endfunction

	function automatic logic [31:0] kind_map(int top);
		logic [31:0] m;
		for (int i = 0; i < 8; i++)
			m[4*i +: 4] = 4'($urandom_range(0, top));
		return m;
	endfunction

	function automatic plan_row_t access_row(logic rt, int p, int k, bit known,
		logic [STAT_W-1:0] st, int sl, bit wv, int wp);
		plan_row_t r;
		r.what = ROW_ACCESS;
		r.c.req_type = rt;
		r.c.proc_id = PROC_W'(p);
		r.c.res_kind = KIND_W'(k);
		r.val = '0;
		r.known = known;
		r.want.status = st;
		r.want.slot_index = SLOT_W'(sl);
		r.want.woken_valid = wv;
		r.want.woken_proc = PROC_W'(wp);
		return r;
	endfunction

	function automatic plan_row_t reg_row(row_e what, logic [31:0] v);
		plan_row_t r;
		r.what = what;
		r.c = '0;
		r.val = v;
		r.known = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			errs++;
			$display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	// Offer one item, hold it until taken, then maybe leave a gap
	task automatic offer(input cmd_item_t c, input bit known, input rsp_item_t want);
		typed_q.push_back('{known: known, want: want});
		cmd <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	// Stop sending and wait for every expected result plus a wait-list walk
	task automatic settle();
		cmd_valid <= 1'b0;
		while (typed_q.size() != 0 || due_q.size() != 0) @(posedge clk);
		repeat (TAIL) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle
	task automatic write_reg(input logic idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'({idx, 2'b00});
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_KINDS) kinds_m = val;
		else count_m = val[CNT_CFG_W-1:0];
		reg_writes++;
		@(posedge clk);
	endtask

	// Accepted access: predict its result
	always @(posedge clk) begin : take_cmd
		typed_rsp_t tag;
		rsp_item_t calc;
		if (arst_n && cmd_valid && !cmd_stall) begin
			tag = typed_q.pop_front();
			calc = lock_access(cmd);
			due_q.push_back(tag.known ? tag.want : calc);
			tally[calc.status]++;
			if (calc.woken_valid) wakes++;
		end
	end

	// Accepted result: compare with the oldest expectation
	always @(posedge clk) begin : take_rsp
		rsp_item_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (due_q.size() == 0) begin
				errs++;
				$display("%0t ns: result with none expected, got %p", $time, rsp);
			end else begin
				want = due_q.pop_front();
				check_field("status", want.status, rsp.status);
				check_field("slot_index", want.slot_index, rsp.slot_index);
				check_field("woken_valid", want.woken_valid, rsp.woken_valid);
				check_field("woken_proc", want.woken_proc, rsp.woken_proc);
			end
		end
	end

	// Result side: random stall bursts, or one long hold-off on request
	initial begin : rsp_side
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				rsp_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				hold_rsp = 1'b0;
				rsp_stall <= 1'b0;
			end else if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct / 3) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	// Stimulus
	initial begin : stimulus
		plan_row_t plan[$];
		arst_n <= 1'b0;
		cmd_valid <= 1'b0;
		cmd <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		kinds_m = KINDS_RST;
		count_m = COUNT_RST;
		for (int s = 0; s < NSLOT; s++) begin
			own_busy[s] = 1'b0;
			own_proc[s] = '0;
		end

		// Directed: all slots kind 0 after reset
		plan.push_back(access_row(REQ_ACQUIRE, 0, 0, 1, ST_GRANTED, 0, 0, 0));
		plan.push_back(access_row(REQ_ACQUIRE, 0, 0, 1, ST_GRANTED, 1, 0, 0));
		plan.push_back(access_row(REQ_ACQUIRE, 15, 15, 1, ST_WAIT, 0, 0, 0));
		plan.push_back(access_row(REQ_ACQUIRE, 15, 0, 1, ST_ALREADY, 0, 0, 0));
		plan.push_back(access_row(REQ_RELEASE, 3, 0, 1, ST_REL_ERROR, 0, 0, 0));
		plan.push_back(access_row(REQ_RELEASE, 15, 15, 1, ST_REL_ERROR, 0, 0, 0));
		// slot 0 changes kind while busy
		plan.push_back(reg_row(ROW_KINDS, 32'hF000_000F));
		plan.push_back(access_row(REQ_RELEASE, 0, 0, 1, ST_RELEASED, 1, 0, 0));
		plan.push_back(access_row(REQ_RELEASE, 0, 15, 1, ST_RELEASED, 0, 1, 15));
		plan.push_back(access_row(REQ_ACQUIRE, 15, 15, 1, ST_GRANTED, 0, 0, 0));
		// no slots in use
		plan.push_back(reg_row(ROW_COUNT, 32'd0));
		plan.push_back(access_row(REQ_ACQUIRE, 1, 0, 1, ST_WAIT, 0, 0, 0));
		plan.push_back(access_row(REQ_RELEASE, 15, 15, 1, ST_REL_ERROR, 0, 0, 0));
		// count above the slot total saturates
		plan.push_back(reg_row(ROW_COUNT, 32'd15));
		plan.push_back(access_row(REQ_ACQUIRE, 2, 15, 1, ST_GRANTED, 7, 0, 0));
		plan.push_back(access_row(REQ_ACQUIRE, 2, 0, 0, ST_GRANTED, 0, 0, 0));
		// one slot: busy slots beyond the count are out of reach
		plan.push_back(reg_row(ROW_COUNT, 32'd1));
		plan.push_back(access_row(REQ_ACQUIRE, 3, 0, 1, ST_WAIT, 0, 0, 0));
		plan.push_back(access_row(REQ_RELEASE, 2, 15, 1, ST_REL_ERROR, 0, 0, 0));
		plan.push_back(access_row(REQ_RELEASE, 15, 15, 1, ST_RELEASED, 0, 0, 0));
		plan.push_back(access_row(REQ_ACQUIRE, 4, 15, 1, ST_GRANTED, 0, 0, 0));
		plan.push_back(access_row(REQ_ACQUIRE, 5, 15, 1, ST_WAIT, 0, 0, 0));
		plan.push_back(access_row(REQ_ACQUIRE, 6, 15, 1, ST_WAIT, 0, 0, 0));
		// oldest waiter of the kind leaves from the middle of the list
		plan.push_back(access_row(REQ_RELEASE, 4, 15, 1, ST_RELEASED, 0, 1, 5));
		plan.push_back(access_row(REQ_RELEASE, 4, 15, 1, ST_REL_ERROR, 0, 0, 0));
		plan.push_back(access_row(REQ_ACQUIRE, 5, 15, 0, ST_GRANTED, 0, 0, 0));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		gap_pct = 20;
		foreach (plan[i]) begin
			case (plan[i].what)
				ROW_ACCESS: offer(plan[i].c, plan[i].known, plan[i].want);
				ROW_KINDS: begin
					settle();
					write_reg(REG_KINDS, plan[i].val);
				end
				default: begin
					settle();
					write_reg(REG_COUNT, plan[i].val);
				end
			endcase
		end

		// Random phases, each under its own slot map and count
		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			case (ph)
				0: begin
					write_reg(REG_KINDS, kind_map(3));
					write_reg(REG_COUNT, 32'd8);
					gap_pct = 15;
				end
				1: begin
					write_reg(REG_COUNT, 32'd0);
					gap_pct = 30;
				end
				2: begin
					write_reg(REG_KINDS, 32'hFFFF_FFFF);
					write_reg(REG_COUNT, 32'd8);
					gap_pct = 10;
				end
				3: begin
					write_reg(REG_KINDS, kind_map(3));
					write_reg(REG_COUNT, 32'd15);
					gap_pct = 50;
				end
				4: begin
					write_reg(REG_KINDS, kind_map(1));
					write_reg(REG_COUNT, 32'($urandom_range(1, 7)));
					gap_pct = 20;
				end
				5: begin
					write_reg(REG_KINDS, $urandom);
					write_reg(REG_COUNT, 32'd8);
					gap_pct = 25;
				end
				6: begin
					write_reg(REG_KINDS, kind_map(3));
					write_reg(REG_COUNT, 32'd8);
					gap_pct = 20;
					hold_rsp = 1'b1;
				end
				default: begin
					write_reg(REG_KINDS, kind_map(2));
					write_reg(REG_COUNT, 32'd8);
					gap_pct = 0;
				end
			endcase
			for (int i = 0; i < phase_len[ph]; i++) begin
				// in odd phases, a sender pause mid-phase until all results are back
				if (ph % 2 == 1 && i == phase_len[ph] / 2) settle();
				offer(next_access(), 1'b0, '0);
			end
		end

		settle();
		$display("Covered %0d grants, %0d waits, %0d releases, %0d bad releases,",
			tally[ST_GRANTED], tally[ST_WAIT], tally[ST_RELEASED], tally[ST_REL_ERROR]);
		$display("%0d repeats and %0d wakes over %0d register writes and one long result stall",
			tally[ST_ALREADY], wakes, reg_writes);
		if (errs == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches", errs);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ----- resource_lock_manager.f -----
hdl/rlm_pkg.sv
hdl/rlm_slot_table.sv
hdl/rlm_wait_list.sv
hdl/resource_lock_manager.sv
tb/tb_resource_lock_manager.sv
